[design/adc_median_clamp_ema_smoother_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the median, clamp and average smoother
// Short forms for the concurrent checks used in the design files.
// ----------------------------------------------------------------------------
`ifndef ADC_MEDIAN_CLAMP_EMA_SMOOTHER_MACROS_SVH
`define ADC_MEDIAN_CLAMP_EMA_SMOOTHER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AMCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication checked in the same cycle.
`define AMCE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/amce_pkg.sv]
// ----------------------------------------------------------------------------
// amce_pkg
// Shared sizes and types of the median, clamp and average smoother.
// ----------------------------------------------------------------------------
package amce_pkg;

  localparam int HistDepth  = 5;
  localparam int SampleBits = 12;

  // Width of the sample and result fields on the ports.
  localparam int DataW   = 12;
  localparam int TdataW  = ((DataW + 7) / 8) * 8;
  localparam int SampleW = (SampleBits < DataW) ? SampleBits : DataW;
  localparam int CountW  = $clog2(HistDepth + 1);
  localparam int RankW   = (HistDepth > 1) ? $clog2(HistDepth) : 1;

  localparam logic [DataW-1:0] SpikeLimitReset = DataW'(400);

  typedef struct packed {
    logic load;  // shift a new sample into the row
    logic rank;  // one rotation and compare step
  } cell_ctl_t;

  typedef struct packed {
    logic [SampleW-1:0] val;
    logic [RankW-1:0]   tag;
  } cell_rot_t;

endpackage

[design/adc_median_clamp_ema_smoother.sv]
// ----------------------------------------------------------------------------
// adc_median_clamp_ema_smoother
// Running median of the last samples, spike clamp and exponential average.
// ----------------------------------------------------------------------------
// Samples arrive on the s_axis stream, one per request, in the low bits of
// s_axis_tdata. Each request yields one smoothed value on the m_axis stream.
// The spike limit is written through the cfg channel, which is always ready;
// write it only while no sample is in flight.
// The history is a row of HistDepth cells. A new sample shifts in at cell 0
// and every cell passes a copy of its sample around the ring, one cell per
// cycle, counting how many stored samples rank below its own. After
// HistDepth such steps the cell whose rank is half the fill count holds the
// median. The result passes through the rank steps, the pick state and the
// update state into the output register, and no new request is taken until
// that result has been written and the block is back in its idle state.
// Reset empties the history, clears the average and loads a spike limit of
// 400. A result waits in the output register while the receiver stalls; the
// next sample is still accepted and processed, and its final step waits until
// the output register is free.
// ----------------------------------------------------------------------------
`include "adc_median_clamp_ema_smoother_macros.svh"

module adc_median_clamp_ema_smoother (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [11:0] sample, [15:12] zero
  input  logic [amce_pkg::TdataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [11:0] smoothed, [15:12] zero
  output logic [amce_pkg::TdataW-1:0]    m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [amce_pkg::DataW-1:0]     cfg_data_i
);
  import amce_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_PICK,
    ST_UPDATE
  } state_e;

  state_e             state_q;
  logic [RankW-1:0]   step_q;
  logic [CountW-1:0]  fill_q;
  logic [SampleW-1:0] median_q;
  logic [DataW-1:0]   limit_q;
  logic               out_valid_q;
  logic [DataW-1:0]   out_data_q;

  cell_ctl_t          ctl;
  cell_rot_t          rot     [HistDepth];
  logic [SampleW-1:0] cell_s  [HistDepth];
  logic [HistDepth-1:0] hit;
  logic [SampleW-1:0] median_sel;
  logic [SampleW-1:0] sample;
  logic [SampleW-1:0] avg_next;
  logic               in_req;
  logic               out_free;
  logic               upd;

  assign sample   = s_axis_tdata[SampleW-1:0];
  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign upd      = (state_q == ST_UPDATE) && out_free;

  assign ctl.load = in_req;
  assign ctl.rank = (state_q == ST_RANK);

  for (genvar i = 0; i < HistDepth; i++) begin : g_cell
    amce_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .idx_i  (RankW'(i)),
      .fill_i (fill_q),
      .s_in_i ((i == 0) ? sample : cell_s[(i + HistDepth - 1) % HistDepth]),
      .rot_i  (rot[(i + HistDepth - 1) % HistDepth]),
      .rot_o  (rot[i]),
      .s_o    (cell_s[i]),
      .hit_o  (hit[i])
    );
  end

  always_comb begin
    median_sel = '0;
    for (int i = 0; i < HistDepth; i++) begin
      median_sel = median_sel | (cell_s[i] & {SampleW{hit[i]}});
    end
  end

  amce_ema u_ema (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .median_i   (median_q),
    .limit_i    (limit_q),
    .avg_next_o (avg_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      fill_q      <= '0;
      median_q    <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && !upd) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            if (fill_q < CountW'(HistDepth)) begin
              fill_q <= fill_q + CountW'(1);
            end
            step_q  <= '0;
            state_q <= ST_RANK;
          end
        end
        ST_RANK: begin
          step_q <= step_q + RankW'(1);
          if (step_q == RankW'(HistDepth - 1)) begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          median_q <= median_sel;
          state_q  <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= DataW'(avg_next);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SpikeLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'(out_data_q);
  assign cfg_ready_o   = 1'b1;

  `AMCE_ASSERT(a_fill_bound, fill_q <= CountW'(HistDepth), "fill count beyond depth")
  `AMCE_ASSERT_IMP(a_busy_filled, state_q != ST_IDLE, fill_q != '0, "busy with empty history")
  `AMCE_ASSERT_IMP(a_one_median, state_q == ST_PICK, $onehot(hit), "median slot not unique")

endmodule

[design/amce_cell.sv]
// ----------------------------------------------------------------------------
// amce_cell
// One history slot: stores a sample and ranks it against a rotating copy.
// ----------------------------------------------------------------------------
module amce_cell (
  input  logic                                    clk_i,
  input  amce_pkg::cell_ctl_t                     ctl_i,
  input  logic [amce_pkg::RankW-1:0]              idx_i,
  input  logic [amce_pkg::CountW-1:0]             fill_i,
  input  logic [amce_pkg::SampleW-1:0]            s_in_i,
  input  amce_pkg::cell_rot_t                     rot_i,
  output amce_pkg::cell_rot_t                     rot_o,
  output logic [amce_pkg::SampleW-1:0]            s_o,
  output logic                                    hit_o
);
  import amce_pkg::*;

  logic [SampleW-1:0] s_q, s_d;
  cell_rot_t          rot_q, rot_d;
  logic [RankW-1:0]   rank_q, rank_d;
  logic               own_valid;
  logic               rot_valid;
  logic               below;

  assign own_valid = CountW'(idx_i) < fill_i;
  assign rot_valid = CountW'(rot_q.tag) < fill_i;

  // Equal values are ordered by slot, so the ranks of valid slots are distinct.
  assign below = rot_valid &&
                 ((rot_q.val < s_q) || ((rot_q.val == s_q) && (rot_q.tag < idx_i)));

  always_comb begin
    s_d    = s_q;
    rot_d  = rot_q;
    rank_d = rank_q;
    if (ctl_i.load) begin
      s_d       = s_in_i;
      rot_d.val = s_in_i;
      rot_d.tag = idx_i;
      rank_d    = '0;
    end else if (ctl_i.rank) begin
      rot_d = rot_i;
      if (below) begin
        rank_d = rank_q + RankW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    rot_q  <= rot_d;
    rank_q <= rank_d;
  end

  assign rot_o = rot_q;
  assign s_o   = s_q;
  assign hit_o = own_valid && (CountW'(rank_q) == (fill_i >> 1));

endmodule

[design/amce_ema.sv]
// ----------------------------------------------------------------------------
// amce_ema
// Clamps the median around the running average and updates the average.
// ----------------------------------------------------------------------------
module amce_ema (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              upd_i,
  input  logic [amce_pkg::SampleW-1:0]      median_i,
  input  logic [amce_pkg::DataW-1:0]        limit_i,
  output logic [amce_pkg::SampleW-1:0]      avg_next_o
);
  import amce_pkg::*;

  localparam int ExtW = DataW + 1;
  localparam int SumW = ExtW + 2;

  logic [SampleW-1:0] avg_q;
  logic               seeded_q;
  logic [ExtW-1:0]    med_e, avg_e, lim_e, clamped;
  logic [SumW-1:0]    sum;

  assign med_e = ExtW'(median_i);
  assign avg_e = ExtW'(avg_q);
  assign lim_e = ExtW'(limit_i);

  always_comb begin
    clamped = med_e;
    if ((med_e > avg_e) && ((med_e - avg_e) > lim_e)) begin
      clamped = avg_e + lim_e;
    end else if ((avg_e > med_e) && ((avg_e - med_e) > lim_e)) begin
      clamped = avg_e - lim_e;
    end
  end

  assign sum = (SumW'(avg_e) << 1) + SumW'(avg_e) + SumW'(clamped);

  // The first sample after reset seeds the average with the median itself.
  assign avg_next_o = seeded_q ? SampleW'(sum >> 2) : median_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q    <= '0;
      seeded_q <= 1'b0;
    end else if (upd_i) begin
      avg_q    <= avg_next_o;
      seeded_q <= 1'b1;
    end
  end

endmodule
